// ----- rtl/ikmc_pkg.sv -----
// shared types, constants and codes for the inertial knob to midi cc block
package ikmc_pkg;

    localparam int KNOB_COUNT    = 22;
    localparam int FRACTION_BITS = 16;

    localparam int KNOB_W   = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;
    localparam int VEL_W    = FRACTION_BITS + 2;
    localparam int POS_W    = FRACTION_BITS + 1;
    localparam int SUM_W    = FRACTION_BITS + 3;
    localparam int NUM_W    = 14;
    localparam int SCALED_W = 14;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam longint FX_ONE   = longint'(1) << FRACTION_BITS;
    localparam longint AMT_FAST = (20 * FX_ONE + 50) / 100;
    localparam longint AMT_NORM = (10 * FX_ONE + 50) / 100;
    localparam longint AMT_SLOW = (5 * FX_ONE + 50) / 100;
    localparam longint AMT_FRIC = (1 * FX_ONE + 50) / 100;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_ASSIGN = 2'd2;

    localparam logic [6:0] SC_UP_A_LO   = 7'd30;
    localparam logic [6:0] SC_UP_A_HI   = 7'd39;
    localparam logic [6:0] SC_DOWN_A_LO = 7'd44;
    localparam logic [6:0] SC_DOWN_A_HI = 7'd53;
    localparam logic [6:0] SC_UP_B_LO   = 7'd2;
    localparam logic [6:0] SC_UP_B_HI   = 7'd13;
    localparam logic [6:0] SC_DOWN_B_LO = 7'd16;
    localparam logic [6:0] SC_DOWN_B_HI = 7'd27;
    localparam logic [6:0] SC_FAST      = 7'd42;
    localparam logic [6:0] SC_SLOW      = 7'd29;
    localparam logic [6:0] BANK_B_BASE  = 7'd10;

    localparam logic [7:0] STATUS_CC    = 8'hB0;
    localparam logic [6:0] CC_RPN_MSB   = 7'd101;
    localparam logic [6:0] CC_RPN_LSB   = 7'd100;
    localparam logic [6:0] CC_NRPN_MSB  = 7'd99;
    localparam logic [6:0] CC_NRPN_LSB  = 7'd98;
    localparam logic [6:0] CC_DATA_MSB  = 7'd6;
    localparam logic [6:0] CC_DATA_LSB  = 7'd38;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CC,
        KIND_RPN,
        KIND_NRPN
    } t_kind;

    typedef enum logic [2:0] {
        CMD_THRUST,
        CMD_FAST,
        CMD_SLOW,
        CMD_TICK,
        CMD_ASSIGN
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op            op;
        logic [KNOB_W-1:0]  knob;
        logic               up;
        logic               level;
        t_kind              kind;
        logic [NUM_W-1:0]   number;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THRUST,
        ST_FRIC,
        ST_MOVE,
        ST_CHECK,
        ST_SEND
    } t_state;

endpackage

// ----- rtl/ikmc_front.sv -----
// front end: takes input transfers and decodes them into knob commands
module ikmc_front (
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_op,
    input  logic [6:0]            i_scan_code,
    input  logic                  i_key_down,
    input  logic [4:0]            i_knob_index,
    input  logic [1:0]            i_ctrl_kind,
    input  logic [13:0]           i_ctrl_number,
    input  logic                  i_q_full,
    output logic                  o_push,
    output ikmc_pkg::t_cmd        o_cmd
);
    import ikmc_pkg::*;

    localparam logic [6:0] KNOB_LIM7 = 7'(KNOB_COUNT);
    localparam logic [4:0] KNOB_LIM5 = 5'(KNOB_COUNT);

    logic       keep;
    logic       is_knob;
    logic [6:0] knob7;
    t_cmd       cmd;

    always_comb begin
        keep    = 1'b0;
        is_knob = 1'b0;
        knob7   = '0;
        cmd     = '0;
        cmd.op  = CMD_TICK;
        case (i_op)
            OP_KEY: begin
                cmd.level = i_key_down;
                if (i_scan_code >= SC_UP_A_LO && i_scan_code <= SC_UP_A_HI) begin
                    knob7   = i_scan_code - SC_UP_A_LO;
                    cmd.up  = 1'b1;
                    is_knob = 1'b1;
                end else if (i_scan_code >= SC_DOWN_A_LO && i_scan_code <= SC_DOWN_A_HI) begin
                    knob7   = i_scan_code - SC_DOWN_A_LO;
                    is_knob = 1'b1;
                end else if (i_scan_code >= SC_UP_B_LO && i_scan_code <= SC_UP_B_HI) begin
                    knob7   = i_scan_code - SC_UP_B_LO + BANK_B_BASE;
                    cmd.up  = 1'b1;
                    is_knob = 1'b1;
                end else if (i_scan_code >= SC_DOWN_B_LO && i_scan_code <= SC_DOWN_B_HI) begin
                    knob7   = i_scan_code - SC_DOWN_B_LO + BANK_B_BASE;
                    is_knob = 1'b1;
                end else if (i_scan_code == SC_FAST) begin
                    cmd.op = CMD_FAST;
                    keep   = 1'b1;
                end else if (i_scan_code == SC_SLOW) begin
                    cmd.op = CMD_SLOW;
                    keep   = 1'b1;
                end
                if (is_knob && knob7 < KNOB_LIM7) begin
                    cmd.op   = CMD_THRUST;
                    cmd.knob = knob7[KNOB_W-1:0];
                    keep     = 1'b1;
                end
            end
            OP_TICK: begin
                cmd.op   = CMD_TICK;
                cmd.knob = i_knob_index[KNOB_W-1:0];
                keep     = (i_knob_index < KNOB_LIM5);
            end
            OP_ASSIGN: begin
                cmd.op     = CMD_ASSIGN;
                cmd.knob   = i_knob_index[KNOB_W-1:0];
                cmd.kind   = t_kind'(i_ctrl_kind);
                cmd.number = i_ctrl_number;
                keep       = (i_knob_index < KNOB_LIM5);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full && keep;
    assign o_cmd      = cmd;

endmodule

// ----- rtl/ikmc_queue.sv -----
// short command queue between the front end and the knob engine
module ikmc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ikmc_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output ikmc_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import ikmc_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic [Q_AW:0]   n_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/ikmc_back.sv -----
// knob engine: knob state, velocity and position update, cc message output
module ikmc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  ikmc_pkg::t_cmd  i_q_cmd,
    output logic            o_pop,
    input  logic            i_cfg_wr_en,
    input  logic [3:0]      i_cfg_wr_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_status_byte,
    output logic [6:0]      o_cc_number,
    output logic [6:0]      o_cc_value,
    output logic            o_last
);
    import ikmc_pkg::*;

    localparam logic signed [SUM_W-1:0] ONE_S   = SUM_W'(FX_ONE);
    localparam logic signed [SUM_W-1:0] NEG_S   = -ONE_S;
    localparam logic signed [SUM_W-1:0] ZERO_S  = '0;
    localparam logic signed [SUM_W-1:0] FAST_S  = SUM_W'(AMT_FAST);
    localparam logic signed [SUM_W-1:0] NORM_S  = SUM_W'(AMT_NORM);
    localparam logic signed [SUM_W-1:0] SLOW_S  = SUM_W'(AMT_SLOW);
    localparam logic signed [SUM_W-1:0] FRIC_S  = SUM_W'(AMT_FRIC);
    localparam logic [1:0]              IDX_END = 2'd3;

    function automatic logic signed [SUM_W-1:0] f_clamp(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] lo,
        input logic signed [SUM_W-1:0] hi
    );
        logic signed [SUM_W-1:0] res;
        res = v;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    function automatic logic [SCALED_W-1:0] f_scaled(
        input t_kind            kind,
        input logic [POS_W-1:0] pos
    );
        logic [POS_W+6:0]    w7;
        logic [POS_W+13:0]   w14;
        logic [SCALED_W-1:0] res;
        w7  = {pos, 7'b0} >> FRACTION_BITS;
        w14 = {pos, 14'b0} >> FRACTION_BITS;
        case (kind)
            KIND_CC: begin
                res = (w7 > (POS_W+7)'(127)) ? SCALED_W'(127) : {7'b0, w7[6:0]};
            end
            KIND_RPN, KIND_NRPN: begin
                res = (w14 > (POS_W+14)'(16383)) ? {SCALED_W{1'b1}} : w14[13:0];
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    t_state                     r_state;
    t_state                     n_state;
    t_kind                      r_kind_tab [KNOB_COUNT];
    logic [NUM_W-1:0]           r_num_tab  [KNOB_COUNT];
    logic signed [VEL_W-1:0]    r_vel_tab  [KNOB_COUNT];
    logic [POS_W-1:0]           r_pos_tab  [KNOB_COUNT];
    logic [KNOB_COUNT-1:0]      r_up;
    logic [KNOB_COUNT-1:0]      r_dn;
    logic                       r_fast;
    logic                       r_slow;
    logic [3:0]                 r_chan;
    logic [KNOB_W-1:0]          r_knob;
    t_kind                      r_cur_kind;
    logic [NUM_W-1:0]           r_cur_num;
    logic signed [VEL_W-1:0]    r_vel_work;
    logic [SCALED_W-1:0]        r_before;
    logic [SCALED_W-1:0]        r_after;
    logic [1:0]                 r_idx;
    logic                       r_out_valid;
    logic [6:0]                 r_cc_number;
    logic [6:0]                 r_cc_value;
    logic                       r_last;

    logic                       out_load;
    logic [6:0]                 msg_num;
    logic [6:0]                 msg_val;
    logic                       msg_last;
    logic signed [VEL_W-1:0]    vel_cur;
    logic [POS_W-1:0]           pos_cur;
    logic signed [SUM_W-1:0]    amount;
    logic signed [SUM_W-1:0]    v_ext;
    logic signed [SUM_W-1:0]    thr_sum;
    logic signed [SUM_W-1:0]    thr_clamp;
    logic signed [VEL_W-1:0]    vel_thr;
    logic signed [SUM_W-1:0]    w_ext;
    logic signed [SUM_W-1:0]    fric_sum;
    logic signed [SUM_W-1:0]    fric_clamp;
    logic signed [VEL_W-1:0]    vel_fric;
    logic signed [SUM_W-1:0]    p_ext;
    logic signed [SUM_W-1:0]    move_sum;
    logic signed [SUM_W-1:0]    move_clamp;
    logic [POS_W-1:0]           pos_new;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_cmd.op == CMD_TICK) begin
                    n_state = ST_THRUST;
                end
            end
            ST_THRUST: n_state = ST_FRIC;
            ST_FRIC:   n_state = ST_MOVE;
            ST_MOVE:   n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_cur_kind == KIND_NONE || r_after == r_before) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (out_load && msg_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs and message select
    always_comb begin
        o_pop    = (r_state == ST_IDLE) && i_q_valid;
        out_load = (r_state == ST_SEND) && (!r_out_valid || !i_out_stall);
        msg_num  = '0;
        msg_val  = '0;
        msg_last = 1'b0;
        if (r_cur_kind == KIND_CC) begin
            msg_num  = r_cur_num[6:0];
            msg_val  = r_after[6:0];
            msg_last = 1'b1;
        end else begin
            case (r_idx)
                2'd0: begin
                    msg_num = (r_cur_kind == KIND_RPN) ? CC_RPN_MSB : CC_NRPN_MSB;
                    msg_val = r_cur_num[13:7];
                end
                2'd1: begin
                    msg_num = (r_cur_kind == KIND_RPN) ? CC_RPN_LSB : CC_NRPN_LSB;
                    msg_val = r_cur_num[6:0];
                end
                2'd2: begin
                    msg_num = CC_DATA_MSB;
                    msg_val = r_after[13:7];
                end
                default: begin
                    msg_num = CC_DATA_LSB;
                    msg_val = r_after[6:0];
                end
            endcase
            msg_last = (r_idx == IDX_END);
        end
    end

    // velocity and position arithmetic
    always_comb begin
        vel_cur = r_vel_tab[r_knob];
        pos_cur = r_pos_tab[r_knob];

        if (r_fast && !r_slow) begin
            amount = FAST_S;
        end else if (r_slow && !r_fast) begin
            amount = SLOW_S;
        end else begin
            amount = NORM_S;
        end

        v_ext = {{(SUM_W-VEL_W){vel_cur[VEL_W-1]}}, vel_cur};
        if (r_up[r_knob] && !r_dn[r_knob]) begin
            thr_sum = v_ext + amount;
        end else if (r_dn[r_knob] && !r_up[r_knob]) begin
            thr_sum = v_ext - amount;
        end else begin
            thr_sum = v_ext;
        end
        thr_clamp = f_clamp(thr_sum, NEG_S, ONE_S);
        vel_thr   = thr_clamp[VEL_W-1:0];

        w_ext = {{(SUM_W-VEL_W){r_vel_work[VEL_W-1]}}, r_vel_work};
        if (w_ext > ZERO_S) begin
            fric_sum = w_ext - FRIC_S;
        end else if (w_ext < ZERO_S) begin
            fric_sum = w_ext + FRIC_S;
        end else begin
            fric_sum = w_ext;
        end
        fric_clamp = f_clamp(fric_sum, NEG_S, ONE_S);
        vel_fric   = fric_clamp[VEL_W-1:0];

        p_ext      = {2'b00, pos_cur};
        move_sum   = p_ext + w_ext;
        move_clamp = f_clamp(move_sum, ZERO_S, ONE_S);
        pos_new    = move_clamp[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_up        <= '0;
            r_dn        <= '0;
            r_fast      <= 1'b0;
            r_slow      <= 1'b0;
            r_chan      <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cur_kind  <= KIND_NONE;
            for (int k = 0; k < KNOB_COUNT; k++) begin
                r_kind_tab[k] <= KIND_NONE;
                r_num_tab[k]  <= '0;
                r_vel_tab[k]  <= '0;
                r_pos_tab[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_chan <= i_cfg_wr_data;
            end
            if (o_pop) begin
                case (i_q_cmd.op)
                    CMD_THRUST: begin
                        if (i_q_cmd.up) begin
                            r_up[i_q_cmd.knob] <= i_q_cmd.level;
                        end else begin
                            r_dn[i_q_cmd.knob] <= i_q_cmd.level;
                        end
                    end
                    CMD_FAST: r_fast <= i_q_cmd.level;
                    CMD_SLOW: r_slow <= i_q_cmd.level;
                    CMD_ASSIGN: begin
                        r_kind_tab[i_q_cmd.knob] <= i_q_cmd.kind;
                        r_num_tab[i_q_cmd.knob]  <= i_q_cmd.number;
                    end
                    CMD_TICK: r_knob <= i_q_cmd.knob;
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_THRUST) begin
                r_vel_work <= vel_thr;
                r_cur_kind <= r_kind_tab[r_knob];
                r_cur_num  <= r_num_tab[r_knob];
                r_before   <= f_scaled(r_kind_tab[r_knob], pos_cur);
            end
            if (r_state == ST_FRIC) begin
                r_vel_tab[r_knob] <= vel_fric;
                r_vel_work        <= vel_fric;
            end
            if (r_state == ST_MOVE) begin
                r_pos_tab[r_knob] <= pos_new;
                r_after           <= f_scaled(r_cur_kind, pos_new);
            end
            if (r_state == ST_CHECK) begin
                r_idx <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_cc_number <= msg_num;
                r_cc_value  <= msg_val;
                r_last      <= msg_last;
                r_idx       <= r_idx + 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status_byte = {STATUS_CC[7:4], r_chan};
    assign o_cc_number   = r_cc_number;
    assign o_cc_value    = r_cc_value;
    assign o_last        = r_last;

endmodule

// ----- rtl/inertial_knob_to_midi_cc_core.sv -----
// top level of the inertial knob to midi cc block
// Twenty-two virtual knobs driven by key, tick and assign transfers, reported
// as MIDI control change messages (one CC, or a four-message RPN/NRPN run per
// tick whose scaled value moved). The front end decodes each input transfer
// in the cycle it arrives and drops ignored items; a two-entry command queue
// lets input continue while the engine works or the output is stalled. The
// engine applies a key or assign command as it pops it; a tick steps through
// thrust, friction, position and compare states, then sends its messages one
// at a time, holding on a stall, and takes no new command until done. The user
// must write the midi channel register only while the block is idle; the block
// itself does not enforce this. It takes effect on the next message.
module inertial_knob_to_midi_cc_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [6:0]  i_scan_code,
    input  logic        i_key_down,
    input  logic [4:0]  i_knob_index,
    input  logic [1:0]  i_ctrl_kind,
    input  logic [13:0] i_ctrl_number,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_status_byte,
    output logic [6:0]  o_cc_number,
    output logic [6:0]  o_cc_value,
    output logic        o_last
);
    import ikmc_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    ikmc_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_scan_code   (i_scan_code),
        .i_key_down    (i_key_down),
        .i_knob_index  (i_knob_index),
        .i_ctrl_kind   (i_ctrl_kind),
        .i_ctrl_number (i_ctrl_number),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    ikmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    ikmc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (head_cmd),
        .o_pop         (q_pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status_byte (o_status_byte),
        .o_cc_number   (o_cc_number),
        .o_cc_value    (o_cc_value),
        .o_last        (o_last)
    );

endmodule

// ----- bench/inertial_knob_to_midi_cc_core_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the inertial knob to midi cc core
module inertial_knob_to_midi_cc_core_test;
    import ikmc_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [6:0] SC_ESCAPE      = 7'd1;
    localparam int         N_DIRECTED     = 25;
    localparam int         ITEMS_PER_PASS = 55;
    localparam int         SETTLE_CYCLES  = 30;
    localparam int         HOLD_CYCLES    = 250;
    localparam int         WATCHDOG_LIMIT = 1500;

    typedef struct packed {
        logic [1:0]       op;
        logic [6:0]       scan;
        logic             down;
        logic [4:0]       knob;
        t_kind            kind;
        logic [NUM_W-1:0] number;
        logic             no_msgs;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] number;
        logic [6:0] value;
        logic       last;
    } t_cc_msg;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [3:0]  i_cfg_wr_data = 4'd0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op          = OP_KEY;
    logic [6:0]  i_scan_code   = 7'd0;
    logic        i_key_down    = 1'b0;
    logic [4:0]  i_knob_index  = 5'd0;
    logic [1:0]  i_ctrl_kind   = 2'd0;
    logic [13:0] i_ctrl_number = 14'd0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [7:0]  o_status_byte;
    logic [6:0]  o_cc_number;
    logic [6:0]  o_cc_value;
    logic        o_last;

    t_kind                   ctl_kind   [KNOB_COUNT];
    logic [NUM_W-1:0]        ctl_number [KNOB_COUNT];
    logic                    push_up    [KNOB_COUNT];
    logic                    push_down  [KNOB_COUNT];
    logic signed [VEL_W-1:0] knob_vel   [KNOB_COUNT];
    logic [POS_W-1:0]        knob_pos   [KNOB_COUNT];
    logic                    fast_mod;
    logic                    slow_mod;
    logic [3:0]              midi_chan;

    t_cc_msg   pending_msgs[$];
    t_cc_msg   tick_msgs[$];
    t_stim_row directed_rows[N_DIRECTED];
    int        fail_count     = 0;
    int        items_sent     = 0;
    int        quiet_cycles   = 0;
    bit        hold_request   = 1'b0;

    inertial_knob_to_midi_cc_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_scan_code   (i_scan_code),
        .i_key_down    (i_key_down),
        .i_knob_index  (i_knob_index),
        .i_ctrl_kind   (i_ctrl_kind),
        .i_ctrl_number (i_ctrl_number),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status_byte (o_status_byte),
        .o_cc_number   (o_cc_number),
        .o_cc_value    (o_cc_value),
        .o_last        (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned scaled_of(t_kind kd, longint pos);
        longint p;
        longint v;
        p = clip(pos, 0, FX_ONE);
        case (kd)
            KIND_CC: begin
                v = (p * 128) >>> FRACTION_BITS;
                return (v > 127) ? 127 : int'(v);
            end
            KIND_RPN, KIND_NRPN: begin
                v = (p * 16384) >>> FRACTION_BITS;
                return (v > 16383) ? 16383 : int'(v);
            end
            default: return 0;
        endcase
    endfunction

    // updates the knob state for one item and leaves any messages in tick_msgs
    task automatic predict_item(input t_stim_row it);
        int          k;
        int          sc;
        bit          is_up;
        longint      amount;
        longint      v;
        longint      p;
        int unsigned was;
        int unsigned now;
        t_kind       kd;
        logic [7:0]  status;
        logic [6:0]  sel_msb;
        logic [6:0]  sel_lsb;
        logic [13:0] num;
        logic [13:0] val;
        tick_msgs.delete();
        k = int'(it.knob);
        sc = int'(it.scan);
        is_up = 1'b0;
        case (it.op)
            OP_KEY: begin
                k = -1;
                if (sc >= SC_UP_A_LO && sc <= SC_UP_A_HI) begin
                    k = sc - int'(SC_UP_A_LO);
                    is_up = 1'b1;
                end else if (sc >= SC_DOWN_A_LO && sc <= SC_DOWN_A_HI) begin
                    k = sc - int'(SC_DOWN_A_LO);
                end else if (sc >= SC_UP_B_LO && sc <= SC_UP_B_HI) begin
                    k = sc - int'(SC_UP_B_LO) + int'(BANK_B_BASE);
                    is_up = 1'b1;
                end else if (sc >= SC_DOWN_B_LO && sc <= SC_DOWN_B_HI) begin
                    k = sc - int'(SC_DOWN_B_LO) + int'(BANK_B_BASE);
                end else if (sc == SC_FAST) begin
                    fast_mod = it.down;
                end else if (sc == SC_SLOW) begin
                    slow_mod = it.down;
                end
                if (k >= 0 && k < KNOB_COUNT) begin
                    if (is_up) begin
                        push_up[k] = it.down;
                    end else begin
                        push_down[k] = it.down;
                    end
                end
            end
            OP_ASSIGN: begin
                if (k < KNOB_COUNT) begin
                    ctl_kind[k] = it.kind;
                    ctl_number[k] = it.number;
                end
            end
            OP_TICK: begin
                if (k < KNOB_COUNT) begin
                    kd = ctl_kind[k];
                    was = scaled_of(kd, longint'(knob_pos[k]));
                    if (fast_mod && !slow_mod) begin
                        amount = AMT_FAST;
                    end else if (slow_mod && !fast_mod) begin
                        amount = AMT_SLOW;
                    end else begin
                        amount = AMT_NORM;
                    end
                    v = longint'(knob_vel[k]);
                    if (push_up[k] && !push_down[k]) begin
                        v = clip(v + amount, -FX_ONE, FX_ONE);
                    end else if (push_down[k] && !push_up[k]) begin
                        v = clip(v - amount, -FX_ONE, FX_ONE);
                    end
                    // friction pulls toward zero once and may overshoot
                    if (v > 0) begin
                        v = clip(v - AMT_FRIC, -FX_ONE, FX_ONE);
                    end else if (v < 0) begin
                        v = clip(v + AMT_FRIC, -FX_ONE, FX_ONE);
                    end
                    p = clip(longint'(knob_pos[k]) + v, 0, FX_ONE);
                    knob_vel[k] = v[VEL_W-1:0];
                    knob_pos[k] = p[POS_W-1:0];
                    now = scaled_of(kd, p);
                    status = STATUS_CC | {4'd0, midi_chan};
                    num = ctl_number[k];
                    val = 14'(now);
                    if (now != was && kd == KIND_CC) begin
                        tick_msgs.push_back('{status, num[6:0], val[6:0], 1'b1});
                    end else if (now != was && kd != KIND_NONE) begin
                        sel_msb = (kd == KIND_RPN) ? CC_RPN_MSB : CC_NRPN_MSB;
                        sel_lsb = (kd == KIND_RPN) ? CC_RPN_LSB : CC_NRPN_LSB;
                        tick_msgs.push_back('{status, sel_msb, num[13:7], 1'b0});
                        tick_msgs.push_back('{status, sel_lsb, num[6:0], 1'b0});
                        tick_msgs.push_back('{status, CC_DATA_MSB, val[13:7], 1'b0});
                        tick_msgs.push_back('{status, CC_DATA_LSB, val[6:0], 1'b1});
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_stim_row make_row(logic [1:0] op, logic [6:0] scan, logic down,
                                           logic [4:0] knob, t_kind kind, logic [13:0] number);
        return '{op, scan, down, knob, kind, number, 1'b0};
    endfunction

    function automatic logic [6:0] knob_key(int k, bit up);
        if (k < BANK_B_BASE) begin
            return up ? 7'(int'(SC_UP_A_LO) + k) : 7'(int'(SC_DOWN_A_LO) + k);
        end
        return up ? 7'(int'(SC_UP_B_LO) + k - int'(BANK_B_BASE))
                  : 7'(int'(SC_DOWN_B_LO) + k - int'(BANK_B_BASE));
    endfunction

    function automatic t_stim_row noise_row();
        return make_row(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                        1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                        t_kind'($urandom_range(0, 3)), 14'($urandom_range(0, 16383)));
    endfunction

    function automatic t_stim_row tick_row(int k);
        return make_row(OP_TICK, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                        5'(k), t_kind'($urandom_range(0, 3)), 14'($urandom_range(0, 16383)));
    endfunction

    // offers one item, waits for the transfer, then predicts its messages
    task automatic send_item(input t_stim_row it, input bit counted);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= it.op;
        i_scan_code   <= it.scan;
        i_key_down    <= it.down;
        i_knob_index  <= it.knob;
        i_ctrl_kind   <= it.kind;
        i_ctrl_number <= it.number;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_item(it);
        if (!it.no_msgs) begin
            foreach (tick_msgs[j]) pending_msgs.push_back(tick_msgs[j]);
        end
        if (counted) items_sent++;
    endtask

    task automatic knob_burst();
        int         k;
        bit         up;
        bit         both;
        logic [6:0] key;
        k = $urandom_range(0, KNOB_COUNT - 1);
        if ($urandom_range(0, 2) == 0) begin
            send_item(make_row(OP_ASSIGN, 7'($urandom_range(0, 127)), 1'b0, 5'(k),
                               ($urandom_range(0, 9) == 0) ? KIND_NONE
                                                           : t_kind'($urandom_range(1, 3)),
                               14'($urandom_range(0, 16383))), 1'b1);
        end
        if ($urandom_range(0, 3) == 0) begin
            send_item(make_row(OP_KEY, ($urandom_range(0, 1) == 0) ? SC_FAST : SC_SLOW,
                               1'($urandom_range(0, 1)), 5'(k), KIND_NONE, 14'd0), 1'b1);
        end
        up = 1'($urandom_range(0, 1));
        key = knob_key(k, up);
        both = ($urandom_range(0, 9) == 0);
        send_item(make_row(OP_KEY, key, 1'b1, 5'(k), KIND_NONE, 14'd0), 1'b1);
        if (both) begin
            send_item(make_row(OP_KEY, knob_key(k, !up), 1'b1, 5'(k), KIND_NONE, 14'd0), 1'b1);
        end
        repeat ($urandom_range(2, 12)) begin
            if ($urandom_range(0, 6) == 0) send_item(noise_row(), 1'b0);
            send_item(tick_row(k), 1'b1);
        end
        if ($urandom_range(0, 9) < 7) begin
            send_item(make_row(OP_KEY, key, 1'b0, 5'(k), KIND_NONE, 14'd0), 1'b1);
        end
        if (both) begin
            send_item(make_row(OP_KEY, knob_key(k, !up), 1'b0, 5'(k), KIND_NONE, 14'd0), 1'b1);
        end
        repeat ($urandom_range(0, 4)) send_item(tick_row(k), 1'b1);
    endtask

    task automatic write_channel(input logic [3:0] ch);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= ch;
        midi_chan = ch;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // waits until every predicted message is out and the command queue has drained
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : out_pacing
        int r;
        int len;
        forever begin
            r = $urandom_range(0, 99);
            if (hold_request) begin
                // long hold-off so the block backs up into its input
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                len = HOLD_CYCLES;
            end else if (r < 55) begin
                i_out_stall <= 1'b0;
                len = $urandom_range(1, 24);
            end else if (r < 90) begin
                i_out_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end else begin
                i_out_stall <= 1'b1;
                len = $urandom_range(8, 40);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : msg_check
        t_cc_msg want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_msgs.size() == 0) begin
                    $error("unexpected transfer: status_byte %0h cc_number %0d cc_value %0d",
                           o_status_byte, o_cc_number, o_cc_value);
                    fail_count++;
                end else begin
                    want = pending_msgs.pop_front();
                    if (o_status_byte !== want.status) begin
                        $error("status_byte expected %0h got %0h", want.status, o_status_byte);
                        fail_count++;
                    end
                    if (o_cc_number !== want.number) begin
                        $error("cc_number expected %0d got %0d", want.number, o_cc_number);
                        fail_count++;
                    end
                    if (o_cc_value !== want.value) begin
                        $error("cc_value expected %0d got %0d", want.value, o_cc_value);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last expected %0d got %0d", want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("inertial_knob_to_midi_cc_core verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int target;
        for (int k = 0; k < KNOB_COUNT; k++) begin
            ctl_kind[k]   = KIND_NONE;
            ctl_number[k] = '0;
            push_up[k]    = 1'b0;
            push_down[k]  = 1'b0;
            knob_vel[k]   = '0;
            knob_pos[k]   = '0;
        end
        fast_mod  = 1'b0;
        slow_mod  = 1'b0;
        midi_chan = 4'd0;

        // rows marked no_msgs carry their expectation here: no transfer at all
        directed_rows = '{
            '{OP_TICK,   7'd0,         1'b0, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_UNUSED, 7'd127,       1'b1, 5'd31, KIND_NRPN, 14'd16383, 1'b1},
            '{OP_TICK,   7'd0,         1'b0, 5'd31, KIND_NONE, 14'd0,     1'b1},
            '{OP_ASSIGN, 7'd0,         1'b0, 5'd22, KIND_CC,   14'd5,     1'b1},
            '{OP_KEY,    SC_ESCAPE,    1'b1, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_ASSIGN, 7'd0,         1'b0, 5'd0,  KIND_CC,   14'd16383, 1'b1},
            '{OP_KEY,    SC_UP_A_LO,   1'b1, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_KEY,    SC_FAST,      1'b1, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_TICK,   7'd0,         1'b0, 5'd0,  KIND_NONE, 14'd0,     1'b0},
            '{OP_KEY,    SC_SLOW,      1'b1, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_TICK,   7'd0,         1'b0, 5'd0,  KIND_NONE, 14'd0,     1'b0},
            '{OP_KEY,    SC_FAST,      1'b0, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_TICK,   7'd0,         1'b0, 5'd0,  KIND_NONE, 14'd0,     1'b0},
            '{OP_ASSIGN, 7'd0,         1'b0, 5'd21, KIND_NRPN, 14'd16383, 1'b1},
            '{OP_KEY,    SC_UP_B_HI,   1'b1, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_KEY,    SC_DOWN_B_HI, 1'b1, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_TICK,   7'd0,         1'b0, 5'd21, KIND_NONE, 14'd0,     1'b1},
            '{OP_KEY,    SC_DOWN_B_HI, 1'b0, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_TICK,   7'd0,         1'b0, 5'd21, KIND_NONE, 14'd0,     1'b0},
            '{OP_ASSIGN, 7'd0,         1'b0, 5'd10, KIND_RPN,  14'd0,     1'b1},
            '{OP_KEY,    SC_UP_B_LO,   1'b1, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_TICK,   7'd0,         1'b0, 5'd10, KIND_NONE, 14'd0,     1'b0},
            '{OP_KEY,    SC_UP_A_LO,   1'b0, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_KEY,    SC_DOWN_A_LO, 1'b1, 5'd0,  KIND_NONE, 14'd0,     1'b1},
            '{OP_TICK,   7'd0,         1'b0, 5'd0,  KIND_NONE, 14'd0,     1'b0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_channel(4'd0);
        for (int i = 0; i < N_DIRECTED; i++) send_item(directed_rows[i], 1'b0);

        for (int pass = 0; pass < 3; pass++) begin
            settle_block();
            case (pass)
                0:       write_channel(4'd15);
                1:       write_channel(4'($urandom_range(1, 14)));
                default: write_channel(4'd0);
            endcase
            if (pass == 1) hold_request = 1'b1;
            target = (pass + 1) * ITEMS_PER_PASS;
            while (items_sent < target) begin
                knob_burst();
            end
        end

        settle_block();
        if (fail_count == 0) begin
            $display("inertial_knob_to_midi_cc_core verification clean");
        end else begin
            $display("inertial_knob_to_midi_cc_core verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ikmc_pkg.sv
rtl/ikmc_front.sv
rtl/ikmc_queue.sv
rtl/ikmc_back.sv
rtl/inertial_knob_to_midi_cc_core.sv
bench/inertial_knob_to_midi_cc_core_test.sv
